### hdl/c8alu_pkg.sv
// ----------------------------------------------------------------------------
// c8alu_pkg
// Operation codes, status bit positions and constants of the 8-bit ALU.
// ----------------------------------------------------------------------------
package c8alu_pkg;

  typedef enum logic [3:0] {
    ACT_ADD  = 4'd0,
    ACT_SUB  = 4'd1,
    ACT_INC  = 4'd2,
    ACT_DEC  = 4'd3,
    ACT_AND  = 4'd4,
    ACT_OR   = 4'd5,
    ACT_EOR  = 4'd6,
    ACT_ROL  = 4'd7,
    ACT_ROR  = 4'd8,
    ACT_ASL  = 4'd9,
    ACT_LSR  = 4'd10,
    ACT_BIT  = 4'd11,
    ACT_CMP  = 4'd12,
    ACT_LOAD = 4'd13
  } action_t;

  localparam int unsigned FL_C = 0;
  localparam int unsigned FL_Z = 1;
  localparam int unsigned FL_D = 3;
  localparam int unsigned FL_V = 6;
  localparam int unsigned FL_N = 7;

  localparam logic [7:0] BCD_NINES  = 8'h99;
  localparam logic [9:0] BCD_ADJ_LO = 10'h006;
  localparam logic [9:0] BCD_ADJ_HI = 10'h060;
  localparam logic [4:0] BCD_DIGIT_MAX = 5'd9;
  localparam logic [5:0] BCD_HIGH_MAX  = 6'd9;

  typedef struct packed {
    logic [7:0] result_byte;
    logic [7:0] status_out;
  } alu_res_t;

endpackage

### hdl/cpu8_alu_with_bcd.sv
// The input and result registers form a two-entry pipeline. An accepted
// request is held in the input stage until the result stage is free.
// Throughput: one request per cycle while out_ready keeps in_ready high.
// Reset: rst_n (synchronous, active low) clears both stage valid bits;
// data registers are not reset.
// ----------------------------------------------------------------------------
// cpu8_alu_with_bcd
// 8-bit ALU with decimal-mode add/subtract, registered in and out.
// ----------------------------------------------------------------------------
module cpu8_alu_with_bcd (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] in_action,
  input  logic [7:0] in_operand_a,
  input  logic [7:0] in_operand_b,
  input  logic [7:0] in_status_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_result_byte,
  output logic [7:0] out_status_out
);

  logic       s1_vld_r;
  logic       s1_vld_nxt;
  logic [3:0] s1_action_r;
  logic [7:0] s1_a_r;
  logic [7:0] s1_b_r;
  logic [7:0] s1_status_r;
  logic       s2_vld_r;
  logic       s2_vld_nxt;
  c8alu_pkg::alu_res_t s2_res_r;
  c8alu_pkg::alu_res_t core_res;

  logic in_acc;
  logic s2_ld;

  assign s2_ld    = s1_vld_r && (!s2_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s2_ld;
  assign in_acc   = in_valid && in_ready;

  c8alu_core u_core (
    .action    (s1_action_r),
    .operand_a (s1_a_r),
    .operand_b (s1_b_r),
    .status_in (s1_status_r),
    .res       (core_res)
  );

  always_comb begin
    s1_vld_nxt = in_acc ? 1'b1 : (s2_ld ? 1'b0 : s1_vld_r);
    s2_vld_nxt = s2_ld ? 1'b1 : ((s2_vld_r && out_ready) ? 1'b0 : s2_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action_r <= in_action;
      s1_a_r      <= in_operand_a;
      s1_b_r      <= in_operand_b;
      s1_status_r <= in_status_in;
    end
    if (s2_ld) begin
      s2_res_r <= core_res;
    end
  end

  assign out_valid       = s2_vld_r;
  assign out_result_byte = s2_res_r.result_byte;
  assign out_status_out  = s2_res_r.status_out;

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s2_vld_r && !out_ready) |-> !in_ready)
    else $error("request taken while both stages are stalled");

  a_acc_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_vld_r)
    else $error("accepted request not held in input stage");

  a_ld_valid: assert property (@(posedge clk) disable iff (!rst_n)
    s2_ld |=> out_valid)
    else $error("result stage load did not raise out_valid");

  a_passthru: assert property (@(posedge clk) disable iff (!rst_n)
    s2_ld |=> (out_status_out[5:2] == $past(s1_status_r[5:2])))
    else $error("untouched status bits changed");

endmodule

### hdl/c8alu_core.sv
// ----------------------------------------------------------------------------
// c8alu_core
// Combinational datapath: binary/BCD add and subtract, increment and
// decrement, logic, shifts and rotates, bit test, compare and load, with the status update.
// ----------------------------------------------------------------------------
module c8alu_core (
  input  logic [3:0]          action,
  input  logic [7:0]          operand_a,
  input  logic [7:0]          operand_b,
  input  logic [7:0]          status_in,
  output c8alu_pkg::alu_res_t res
);

  logic       cin;
  logic       dec_mode;
  logic [7:0] bp;
  logic [4:0] lo_sum;
  logic [9:0] sum0;
  logic [9:0] sum1;
  logic [9:0] sum2;
  logic [8:0] cmp_sum;

  always_comb begin
    cin      = status_in[c8alu_pkg::FL_C];
    dec_mode = status_in[c8alu_pkg::FL_D];
    if (c8alu_pkg::action_t'(action) == c8alu_pkg::ACT_SUB) begin
      bp = dec_mode ? (c8alu_pkg::BCD_NINES - operand_b) : ~operand_b;
    end else begin
      bp = operand_b;
    end
    lo_sum = {1'b0, operand_a[3:0]} + {1'b0, bp[3:0]} + {4'd0, cin};
    sum0   = {2'b00, operand_a} + {2'b00, bp} + {9'd0, cin};
    sum1   = (dec_mode && (lo_sum > c8alu_pkg::BCD_DIGIT_MAX)) ?
             sum0 + c8alu_pkg::BCD_ADJ_LO : sum0;
    sum2   = (dec_mode && (sum1[9:4] > c8alu_pkg::BCD_HIGH_MAX)) ?
             sum1 + c8alu_pkg::BCD_ADJ_HI : sum1;
    cmp_sum = {1'b0, operand_a} + {1'b0, ~operand_b} + 9'd1;
  end

  logic [7:0] r;
  logic [7:0] st;
  logic       set_nz;

  always_comb begin
    r      = operand_a;
    st     = status_in;
    set_nz = 1'b0;
    unique case (c8alu_pkg::action_t'(action))
      c8alu_pkg::ACT_ADD, c8alu_pkg::ACT_SUB: begin
        r      = sum2[7:0];
        set_nz = 1'b1;
        st[c8alu_pkg::FL_C] = |sum2[9:8];
        st[c8alu_pkg::FL_V] = (operand_a[7] ^ sum2[7]) & (bp[7] ^ sum2[7]);
      end
      c8alu_pkg::ACT_INC: begin
        r      = operand_a + 8'd1;
        set_nz = 1'b1;
      end
      c8alu_pkg::ACT_DEC: begin
        r      = operand_a - 8'd1;
        set_nz = 1'b1;
      end
      c8alu_pkg::ACT_AND: begin
        r      = operand_a & operand_b;
        set_nz = 1'b1;
      end
      c8alu_pkg::ACT_OR: begin
        r      = operand_a | operand_b;
        set_nz = 1'b1;
      end
      c8alu_pkg::ACT_EOR: begin
        r      = operand_a ^ operand_b;
        set_nz = 1'b1;
      end
      c8alu_pkg::ACT_ROL: begin
        r      = {operand_a[6:0], cin};
        set_nz = 1'b1;
        st[c8alu_pkg::FL_C] = operand_a[7];
      end
      c8alu_pkg::ACT_ROR: begin
        r      = {cin, operand_a[7:1]};
        set_nz = 1'b1;
        st[c8alu_pkg::FL_C] = operand_a[0];
      end
      c8alu_pkg::ACT_ASL: begin
        r      = {operand_a[6:0], 1'b0};
        set_nz = 1'b1;
        st[c8alu_pkg::FL_C] = operand_a[7];
      end
      c8alu_pkg::ACT_LSR: begin
        r      = {1'b0, operand_a[7:1]};
        set_nz = 1'b1;
        st[c8alu_pkg::FL_C] = operand_a[0];
      end
      c8alu_pkg::ACT_BIT: begin
        r = operand_a & operand_b;
        st[c8alu_pkg::FL_Z] = (r == 8'h00);
        st[c8alu_pkg::FL_V] = operand_b[6];
        st[c8alu_pkg::FL_N] = operand_b[7];
      end
      c8alu_pkg::ACT_CMP: begin
        r      = cmp_sum[7:0];
        set_nz = 1'b1;
        st[c8alu_pkg::FL_C] = cmp_sum[8];
      end
      c8alu_pkg::ACT_LOAD: begin
        r      = operand_a;
        set_nz = 1'b1;
      end
      default: begin
        r = operand_a;
      end
    endcase
    if (set_nz) begin
      st[c8alu_pkg::FL_Z] = (r == 8'h00);
      st[c8alu_pkg::FL_N] = r[7];
    end
    res.result_byte = r;
    res.status_out  = st;
  end

endmodule

### sim/cpu8_alu_with_bcd_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cpu8_alu_with_bcd_tb
// Drives ALU requests through the valid/ready input channel and checks each
// result byte and status byte against an in-bench model of the operations.
// Covers directed edge cases, decimal add/subtract, random operations,
// random sender bursts and gaps, random receiver stalls, and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module cpu8_alu_with_bcd_tb;

  localparam logic [7:0] ST_C = 8'(1 << c8alu_pkg::FL_C);
  localparam logic [7:0] ST_Z = 8'(1 << c8alu_pkg::FL_Z);
  localparam logic [7:0] ST_D = 8'(1 << c8alu_pkg::FL_D);
  localparam logic [7:0] ST_V = 8'(1 << c8alu_pkg::FL_V);
  localparam logic [7:0] ST_N = 8'(1 << c8alu_pkg::FL_N);
  localparam int HOLD_CYCLES = 150;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [3:0] in_action;
  logic [7:0] in_operand_a;
  logic [7:0] in_operand_b;
  logic [7:0] in_status_in;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_result_byte;
  logic [7:0] out_status_out;

  c8alu_pkg::alu_res_t alu_results_due[$];
  int       fault_count = 0;
  int       burst_left  = 0;
  bit       gaps_on     = 1'b1;
  bit       hold_off_req = 1'b0;

  cpu8_alu_with_bcd uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_operand_a    (in_operand_a),
    .in_operand_b    (in_operand_b),
    .in_status_in    (in_status_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_byte (out_result_byte),
    .out_status_out  (out_status_out)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic c8alu_pkg::alu_res_t predict_alu(c8alu_pkg::action_t op,
                                                      logic [7:0] a, logic [7:0] b,
                                                      logic [7:0] st);
    c8alu_pkg::alu_res_t res;
    logic [7:0]  r;
    logic [7:0]  bp;
    logic [15:0] s;
    logic        cin;
    r   = a;
    bp  = b;
    cin = st[c8alu_pkg::FL_C];
    s   = '0;
    case (op)
      c8alu_pkg::ACT_ADD, c8alu_pkg::ACT_SUB: begin
        if (op == c8alu_pkg::ACT_SUB) bp = st[c8alu_pkg::FL_D] ? 8'(8'h99 - b) : ~b;
        s = a + bp + cin;
        if (st[c8alu_pkg::FL_D]) begin
          if (a[3:0] + bp[3:0] + cin > 9) s = s + 16'h06;
          if ((s >> 4) > 9) s = s + 16'h60;
        end
        r = s[7:0];
        st[c8alu_pkg::FL_C] = s[15:8] != 0;
        st[c8alu_pkg::FL_Z] = r == 0;
        st[c8alu_pkg::FL_N] = r[7];
        st[c8alu_pkg::FL_V] = (a[7] ^ r[7]) & (bp[7] ^ r[7]);
      end
      c8alu_pkg::ACT_INC:  r = a + 8'd1;
      c8alu_pkg::ACT_DEC:  r = a - 8'd1;
      c8alu_pkg::ACT_AND:  r = a & b;
      c8alu_pkg::ACT_OR:   r = a | b;
      c8alu_pkg::ACT_EOR:  r = a ^ b;
      c8alu_pkg::ACT_ROL:  r = {a[6:0], cin};
      c8alu_pkg::ACT_ROR:  r = {cin, a[7:1]};
      c8alu_pkg::ACT_ASL:  r = {a[6:0], 1'b0};
      c8alu_pkg::ACT_LSR:  r = {1'b0, a[7:1]};
      c8alu_pkg::ACT_BIT: begin
        r = a & b;
        st[c8alu_pkg::FL_Z] = r == 0;
        st[c8alu_pkg::FL_V] = b[6];
        st[c8alu_pkg::FL_N] = b[7];
      end
      c8alu_pkg::ACT_CMP: begin
        s = a + {8'h00, ~b} + 16'd1;
        r = s[7:0];
        st[c8alu_pkg::FL_C] = s[15:8] != 0;
      end
      c8alu_pkg::ACT_LOAD: r = a;
      default:  r = a;
    endcase
    case (op)
      c8alu_pkg::ACT_INC, c8alu_pkg::ACT_DEC, c8alu_pkg::ACT_AND, c8alu_pkg::ACT_OR,
      c8alu_pkg::ACT_EOR, c8alu_pkg::ACT_ROL, c8alu_pkg::ACT_ROR, c8alu_pkg::ACT_ASL,
      c8alu_pkg::ACT_LSR, c8alu_pkg::ACT_CMP, c8alu_pkg::ACT_LOAD: begin
        st[c8alu_pkg::FL_Z] = r == 0;
        st[c8alu_pkg::FL_N] = r[7];
      end
      default: ;
    endcase
    case (op)
      c8alu_pkg::ACT_ROL, c8alu_pkg::ACT_ASL: st[c8alu_pkg::FL_C] = a[7];
      c8alu_pkg::ACT_ROR, c8alu_pkg::ACT_LSR: st[c8alu_pkg::FL_C] = a[0];
      default: ;
    endcase
    res.result_byte = r;
    res.status_out  = st;
    return res;
  endfunction

  // scoreboard: predict on request acceptance, compare on result acceptance
  always @(posedge clk) begin
    c8alu_pkg::alu_res_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        alu_results_due.push_back(predict_alu(c8alu_pkg::action_t'(in_action),
                                              in_operand_a, in_operand_b,
                                              in_status_in));
      if (out_valid && out_ready) begin
        if (alu_results_due.size() == 0) begin
          $error("unexpected result: result_byte %02h status_out %02h",
                 out_result_byte, out_status_out);
          fault_count++;
        end else begin
          want = alu_results_due.pop_front();
          if (out_result_byte !== want.result_byte) begin
            $error("result_byte: expected %02h, actual %02h", want.result_byte,
                   out_result_byte);
            fault_count++;
          end
          if (out_status_out !== want.status_out) begin
            $error("status_out: expected %02h, actual %02h", want.status_out,
                   out_status_out);
            fault_count++;
          end
        end
      end
    end
  end

  // result side stall pattern
  initial begin
    int seg_left;
    int seg_kind;
    int hold_left;
    int phase;
    seg_left  = 0;
    seg_kind  = 0;
    hold_left = 0;
    phase     = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(4, 40);
          seg_kind = $urandom_range(0, 3);
        end
        seg_left--;
        case (seg_kind)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (phase % 3 != 0);
        endcase
      end
    end
  end

  task automatic send_request(input c8alu_pkg::action_t op, input logic [7:0] a,
                              input logic [7:0] b, input logic [7:0] st);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) gap = $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    in_status_in <= st;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (alu_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'h80;
      3:       return 8'h7f;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_bcd();
    if ($urandom_range(0, 4) == 0) return 8'($urandom);
    return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
  endfunction

  task automatic test_directed_arith();
    send_request(c8alu_pkg::ACT_ADD, 8'h00, 8'h00, 8'h00);
    send_request(c8alu_pkg::ACT_ADD, 8'hff, 8'h01, 8'h00);
    send_request(c8alu_pkg::ACT_ADD, 8'h7f, 8'h01, ST_Z);
    send_request(c8alu_pkg::ACT_ADD, 8'h80, 8'h80, ST_C | ST_N);
    send_request(c8alu_pkg::ACT_SUB, 8'h00, 8'h01, ST_C);
    send_request(c8alu_pkg::ACT_SUB, 8'h80, 8'h01, ST_C | ST_V);
    send_request(c8alu_pkg::ACT_ADD, 8'h09, 8'h01, ST_D);
    send_request(c8alu_pkg::ACT_ADD, 8'h99, 8'h01, ST_D | ST_C);
    send_request(c8alu_pkg::ACT_ADD, 8'h58, 8'h46, ST_D | ST_C);
    send_request(c8alu_pkg::ACT_ADD, 8'h0f, 8'h0f, ST_D);
    send_request(c8alu_pkg::ACT_ADD, 8'hff, 8'hff, ST_D | ST_C | 8'h34);
    send_request(c8alu_pkg::ACT_SUB, 8'h00, 8'h01, ST_D | ST_C);
    send_request(c8alu_pkg::ACT_SUB, 8'h46, 8'h12, ST_D | ST_C);
    send_request(c8alu_pkg::ACT_SUB, 8'h00, 8'h00, ST_D);
    wait_drained();
  endtask

  task automatic test_directed_logic();
    send_request(c8alu_pkg::ACT_INC, 8'hff, 8'h00, ST_N);
    send_request(c8alu_pkg::ACT_DEC, 8'h00, 8'hff, ST_Z | ST_C);
    send_request(c8alu_pkg::ACT_AND, 8'hf0, 8'h0f, ST_V);
    send_request(c8alu_pkg::ACT_OR, 8'h80, 8'h01, 8'h00);
    send_request(c8alu_pkg::ACT_EOR, 8'hff, 8'hff, ST_D);
    send_request(c8alu_pkg::ACT_ROL, 8'h80, 8'h00, ST_C);
    send_request(c8alu_pkg::ACT_ROR, 8'h01, 8'h00, 8'h00);
    send_request(c8alu_pkg::ACT_ASL, 8'h80, 8'h00, ST_N);
    send_request(c8alu_pkg::ACT_LSR, 8'h01, 8'h00, ST_N);
    send_request(c8alu_pkg::ACT_BIT, 8'h0f, 8'hc0, 8'h00);
    send_request(c8alu_pkg::ACT_CMP, 8'h40, 8'h40, ST_D | ST_V);
    send_request(c8alu_pkg::ACT_CMP, 8'h10, 8'h20, ST_C);
    send_request(c8alu_pkg::ACT_LOAD, 8'h00, 8'h55, 8'hff);
    send_request(c8alu_pkg::ACT_LOAD, 8'h80, 8'h00, 8'h00);
    wait_drained();
  endtask

  task automatic test_random_ops(input int count);
    gaps_on = ($urandom_range(0, 1) == 1);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) gaps_on = ~gaps_on;
      send_request(c8alu_pkg::action_t'($urandom_range(c8alu_pkg::ACT_ADD,
                                                       c8alu_pkg::ACT_LOAD)),
                   pick_byte(), pick_byte(), 8'($urandom));
    end
    gaps_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_decimal_mode(input int count);
    for (int i = 0; i < count; i++)
      send_request($urandom_range(0, 1) ? c8alu_pkg::ACT_SUB : c8alu_pkg::ACT_ADD,
                   pick_bcd(), pick_bcd(), 8'($urandom) | ST_D);
    wait_drained();
  endtask

  task automatic test_backpressure(input int count);
    gaps_on = 1'b0;
    burst_left = 0;
    hold_off_req = 1'b1;
    for (int i = 0; i < count; i++)
      send_request(c8alu_pkg::action_t'($urandom_range(c8alu_pkg::ACT_ADD,
                                                       c8alu_pkg::ACT_LOAD)),
                   pick_byte(), pick_byte(), 8'($urandom));
    gaps_on = 1'b1;
    wait_drained();
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_action    <= c8alu_pkg::ACT_ADD;
    in_operand_a <= 8'h00;
    in_operand_b <= 8'h00;
    in_status_in <= 8'h00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_arith();
    test_directed_logic();
    test_random_ops(700);
    test_backpressure(40);
    test_decimal_mode(150);
    repeat (8) @(posedge clk);
    if (fault_count == 0)
      $display("cpu8_alu_with_bcd_tb: done, clean");
    else
      $display("cpu8_alu_with_bcd_tb: done, errors");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("cpu8_alu_with_bcd_tb: done, errors");
    $finish;
  end

endmodule
